### design/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define GSP_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) \
    else $error("gas sensor check failed");

// Check that a condition implies a consequence in the same cycle
`define GSP_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("gas sensor implication failed");

`endif

### design/gsp_pkg.sv
// Shared types, register codes and the exp2 coefficient table for the
// gas sensor ppm converter. No dependencies.
`default_nettype none
package gsp_pkg;

  localparam int SAMPLES_DEF    = 10;
  localparam int FULL_SCALE_DEF = 4095;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_LOAD_RES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAN_RES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING   = 3'd4;

  typedef struct packed {
    logic [15:0]        load_res;
    logic [15:0]        clean_res;
    logic [23:0]        scale;
    logic signed [15:0] exponent;
    logic [23:0]        ceiling;
  } cfg_t;

  // Integer square root, bit by bit
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] v;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    v = x;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q30 value of 2^(2^-k)
  function automatic logic [30:0] exp_coef(input int k);
    logic [63:0] c;
    c = isqrt64(64'h2000_0000_0000_0000);
    for (int j = 2; j <= k; j++) begin
      c = isqrt64(c << 30);
    end
    return c[30:0];
  endfunction

  // Entry i holds the factor for fraction bit of weight 2^-(i+1)
  localparam logic [30:0] EXP_COEF [16] = '{
    exp_coef(1),  exp_coef(2),  exp_coef(3),  exp_coef(4),
    exp_coef(5),  exp_coef(6),  exp_coef(7),  exp_coef(8),
    exp_coef(9),  exp_coef(10), exp_coef(11), exp_coef(12),
    exp_coef(13), exp_coef(14), exp_coef(15), exp_coef(16)
  };

endpackage
`default_nettype wire

### design/gsp_front.sv
// Sample accumulator: sums groups of samples and pushes each group sum.
// Depends on gsp_pkg for its parameter defaults.
`default_nettype none
module gsp_front #(
  parameter int SAMPLES        = gsp_pkg::SAMPLES_DEF,
  parameter int ADC_FULL_SCALE = gsp_pkg::FULL_SCALE_DEF,
  parameter int SUM_W          = 17
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             sample_valid,
  output logic                  sample_stall,
  input  wire logic [11:0]      adc_sample,
  input  wire logic             q_full,
  output logic                  push,
  output logic [SUM_W-1:0]      push_data
);
  localparam int CNT_W = $clog2(SAMPLES + 1);

  logic [CNT_W-1:0] sample_count;
  logic [SUM_W-1:0] sample_sum;
  logic [15:0]      clipped;
  logic [SUM_W-1:0] sum_next;
  logic             accept;
  logic             last;

  // Hold samples while the queue has no room
  assign sample_stall = q_full;
  assign accept       = sample_valid && !sample_stall;

  // Clip to full scale and add
  assign clipped  = ({4'b0, adc_sample} > 16'(ADC_FULL_SCALE)) ?
                    16'(ADC_FULL_SCALE) : {4'b0, adc_sample};
  assign sum_next = sample_sum + SUM_W'(clipped);
  assign last     = (sample_count == CNT_W'(SAMPLES - 1));

  assign push      = accept && last;
  assign push_data = sum_next;

  // Advance the group count and sum
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      sample_sum   <= '0;
    end else if (accept) begin
      if (last) begin
        sample_count <= '0;
        sample_sum   <= '0;
      end else begin
        sample_count <= sample_count + 1'b1;
        sample_sum   <= sum_next;
      end
    end
  end
endmodule
`default_nettype wire

### design/gsp_queue.sv
// Two-entry queue of group sums between the accumulator and the engine.
// No package dependencies.
`default_nettype none
module gsp_queue #(
  parameter int WIDTH = 17
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      pop_data
);
  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign pop_data  = mem[rd_ptr];

  // Write entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end
endmodule
`default_nettype wire

### design/gsp_back.sv
// Conversion engine: log2 of four operands, exponent product, exp2 and
// scaling, with the result register. Depends on gsp_pkg.
`default_nettype none
module gsp_back #(
  parameter int SAMPLES        = gsp_pkg::SAMPLES_DEF,
  parameter int ADC_FULL_SCALE = gsp_pkg::FULL_SCALE_DEF,
  parameter int SUM_W          = 17
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire gsp_pkg::cfg_t     cfg,
  input  wire logic              q_valid,
  input  wire logic [SUM_W-1:0]  q_data,
  output logic                   pop,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic [31:0]            ppm_q8,
  output logic                   reading_ok,
  output logic                   in_range
);
  localparam int TOTAL = SAMPLES * ADC_FULL_SCALE;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NORM  = 4'd1;
  localparam logic [3:0] S_SQ    = 4'd2;
  localparam logic [3:0] S_ACC   = 4'd3;
  localparam logic [3:0] S_MULB  = 4'd4;
  localparam logic [3:0] S_EXP   = 4'd5;
  localparam logic [3:0] S_MULA  = 4'd6;
  localparam logic [3:0] S_SHIFT = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]         state;
  logic [SUM_W-1:0]   sum_r;
  logic               ok_r;
  logic [1:0]         op_idx;
  logic [31:0]        x_m;
  logic [4:0]         n_r;
  logic [3:0]         step;
  logic [15:0]        frac;
  logic signed [24:0] lsum;
  logic signed [28:0] e_r;
  logic [30:0]        p_r;
  logic [54:0]        prod;
  logic [31:0]        ppm_r;

  logic               ok_in;
  logic [31:0]        next_opnd;
  logic [63:0]        sq;
  logic [20:0]        lval;
  logic signed [40:0] bl;
  logic [61:0]        pc;
  logic signed [13:0] sh;
  logic [13:0]        neg;
  logic [5:0]         ls;
  logic [54:0]        hi;
  logic [54:0]        lo;
  logic [31:0]        ppm_sat;
  logic               out_free;

  assign ok_in    = (q_data != '0) && (q_data < SUM_W'(TOTAL));
  assign out_free = !result_valid || !result_stall;
  assign pop      = (state == S_IDLE) && q_valid;

  // Pick the operand after the current one
  always_comb begin
    case (op_idx)
      2'd0:    next_opnd = 32'(SUM_W'(TOTAL) - sum_r);
      2'd1:    next_opnd = 32'(sum_r);
      2'd2:    next_opnd = 32'(cfg.clean_res);
      default: next_opnd = 32'(cfg.load_res);
    endcase
  end

  assign sq   = x_m * x_m;
  assign lval = {n_r, frac};
  assign bl   = cfg.exponent * lsum;
  assign pc   = p_r * gsp_pkg::EXP_COEF[step];
  assign sh   = {e_r[28], e_r[28:16]} - 14'sd30;
  assign neg  = -sh;

  // Scale by the integer power and saturate
  always_comb begin
    ls      = sh[5:0];
    hi      = '0;
    lo      = '0;
    ppm_sat = '0;
    if (prod == '0) begin
      ppm_sat = '0;
    end else if (!sh[13]) begin
      if (sh > 14'sd32) begin
        ppm_sat = '1;
      end else begin
        hi = prod >> (6'd32 - ls);
        lo = prod << ls;
        ppm_sat = (hi != '0) ? '1 : lo[31:0];
      end
    end else if (neg >= 14'd55) begin
      ppm_sat = '0;
    end else begin
      lo = prod >> neg[5:0];
      ppm_sat = (lo[54:32] != '0) ? '1 : lo[31:0];
    end
  end

  // Sequence the conversion
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      // Drop a taken reading unless the next one is loaded now
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            sum_r <= q_data;
            ok_r  <= ok_in;
            if (ok_in && cfg.load_res != '0 && cfg.clean_res != '0) begin
              op_idx <= 2'd0;
              x_m    <= 32'(cfg.load_res);
              n_r    <= 5'd31;
              step   <= '0;
              lsum   <= '0;
              state  <= S_NORM;
            end else begin
              ppm_r <= '0;
              state <= S_DONE;
            end
          end
        end
        S_NORM: begin
          case (step[2:0])
            3'd0: if (x_m[31:16] == '0) begin x_m <= x_m << 16; n_r <= n_r - 5'd16; end
            3'd1: if (x_m[31:24] == '0) begin x_m <= x_m << 8;  n_r <= n_r - 5'd8;  end
            3'd2: if (x_m[31:28] == '0) begin x_m <= x_m << 4;  n_r <= n_r - 5'd4;  end
            3'd3: if (x_m[31:30] == '0) begin x_m <= x_m << 2;  n_r <= n_r - 5'd2;  end
            default: if (!x_m[31]) begin x_m <= x_m << 1; n_r <= n_r - 5'd1; end
          endcase
          if (step == 4'd4) begin
            step  <= '0;
            frac  <= '0;
            state <= S_SQ;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_SQ: begin
          x_m  <= sq[63] ? sq[63:32] : sq[62:31];
          frac <= {frac[14:0], sq[63]};
          step <= step + 4'd1;
          if (step == 4'd15) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (op_idx[1]) begin
            lsum <= lsum - $signed({4'b0, lval});
          end else begin
            lsum <= lsum + $signed({4'b0, lval});
          end
          if (op_idx == 2'd3) begin
            state <= S_MULB;
          end else begin
            op_idx <= op_idx + 2'd1;
            x_m    <= next_opnd;
            n_r    <= 5'd31;
            step   <= '0;
            state  <= S_NORM;
          end
        end
        S_MULB: begin
          e_r   <= bl[40:12];
          p_r   <= 31'h4000_0000;
          step  <= '0;
          state <= S_EXP;
        end
        S_EXP: begin
          if (e_r[~step]) begin
            p_r <= pc[60:30];
          end
          step <= step + 4'd1;
          if (step == 4'd15) begin
            state <= S_MULA;
          end
        end
        S_MULA: begin
          prod  <= cfg.scale * p_r;
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          ppm_r <= ppm_sat;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            result_valid <= 1'b1;
            ppm_q8       <= ppm_r;
            reading_ok   <= ok_r;
            in_range     <= ok_r && (ppm_r[31:8] < cfg.ceiling);
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### design/gas_sensor_ppm_converter.sv
// Top level of the gas sensor ppm converter: configuration registers,
// accumulator, sum queue and conversion engine. Depends on gsp_pkg.
//
// Samples are taken whenever the queue has room; every SAMPLES samples the
// group sum enters a two-entry queue, and the conversion engine turns it
// into one reading by four log2 passes on the shared squaring multiplier,
// 16 exp2 steps and a scaling multiply and shift, taking the next sum only
// when idle. Samples are stalled only while the queue is full. Readings with
// a zero or full-scale sum, or a zero resistance register, skip these steps.
// Configuration is always ready and must be written while idle.
`default_nettype none
module gas_sensor_ppm_converter #(
  parameter int SAMPLES        = gsp_pkg::SAMPLES_DEF,
  parameter int ADC_FULL_SCALE = gsp_pkg::FULL_SCALE_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             sample_valid,
  output logic                                  sample_stall,
  input  wire logic [11:0]                      adc_sample,
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output logic [31:0]                           ppm_q8,
  output logic                                  reading_ok,
  output logic                                  in_range,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [gsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gsp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  localparam int SUM_W = $clog2(SAMPLES * ADC_FULL_SCALE + 1);

  gsp_pkg::cfg_t    cfg;
  logic             q_full;
  logic             push;
  logic [SUM_W-1:0] push_data;
  logic             pop;
  logic             q_valid;
  logic [SUM_W-1:0] q_data;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.load_res  <= 16'd2560;
      cfg.clean_res <= 16'd2560;
      cfg.scale     <= 24'd259072;
      cfg.exponent  <= -16'sd11411;
      cfg.ceiling   <= 24'd100000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gsp_pkg::REG_LOAD_RES:  cfg.load_res  <= cfg_data[15:0];
        gsp_pkg::REG_CLEAN_RES: cfg.clean_res <= cfg_data[15:0];
        gsp_pkg::REG_SCALE:     cfg.scale     <= cfg_data;
        gsp_pkg::REG_EXPONENT:  cfg.exponent  <= $signed(cfg_data[15:0]);
        gsp_pkg::REG_CEILING:   cfg.ceiling   <= cfg_data;
        default: ;
      endcase
    end
  end

  gsp_front #(
    .SAMPLES(SAMPLES), .ADC_FULL_SCALE(ADC_FULL_SCALE), .SUM_W(SUM_W)
  ) u_front (
    .clk, .rst, .sample_valid, .sample_stall, .adc_sample,
    .q_full, .push, .push_data
  );

  gsp_queue #(.WIDTH(SUM_W)) u_queue (
    .clk, .rst, .push, .push_data, .full(q_full),
    .pop, .not_empty(q_valid), .pop_data(q_data)
  );

  gsp_back #(
    .SAMPLES(SAMPLES), .ADC_FULL_SCALE(ADC_FULL_SCALE), .SUM_W(SUM_W)
  ) u_back (
    .clk, .rst, .cfg, .q_valid, .q_data, .pop,
    .result_valid, .result_stall, .ppm_q8, .reading_ok, .in_range
  );
endmodule
`default_nettype wire

### design/gsp_checker.sv
// Port-level checks for the gas sensor ppm converter, bound to the top.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module gsp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        result_valid,
  input wire logic        result_stall,
  input wire logic [31:0] ppm_q8,
  input wire logic        reading_ok,
  input wire logic        in_range,
  input wire logic        cfg_ready
);
  // A stalled reading stays offered
  `GSP_ASSERT(a_hold, clk, rst, result_valid && result_stall |=> result_valid)
  // An invalid reading carries no concentration
  `GSP_ASSERT_IMPL(a_bad_zero, clk, rst, result_valid && !reading_ok, ppm_q8 == 32'd0 && !in_range)
  // In range requires a valid reading
  `GSP_ASSERT_IMPL(a_range_ok, clk, rst, result_valid && in_range, reading_ok)
  // A saturated reading is never in range
  `GSP_ASSERT_IMPL(a_range_sat, clk, rst, result_valid && in_range, ppm_q8[31:8] != 24'hFFFFFF)
  // Configuration is always taken
  `GSP_ASSERT(a_cfg_ready, clk, rst, cfg_ready)
endmodule

bind gas_sensor_ppm_converter gsp_checker u_checker (
  .clk, .rst, .result_valid, .result_stall, .ppm_q8, .reading_ok, .in_range,
  .cfg_ready
);
`default_nettype wire
